FILE: sv/blend_factor_apply_macros.svh
// Assertion macros used by the checker file.
`ifndef BLEND_FACTOR_APPLY_MACROS_SVH
`define BLEND_FACTOR_APPLY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Types, constants and helpers for the blend factor pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    localparam int CHAN_W = 8;
    localparam int LANES  = 4;
    localparam int PIX_W  = CHAN_W * LANES;
    localparam int PROD_W = 2 * CHAN_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // Factor select codes
    typedef enum logic [3:0] {
        FN_ZERO      = 4'd0,
        FN_ONE       = 4'd1,
        FN_SRC       = 4'd2,
        FN_INV_SRC   = 4'd3,
        FN_DST       = 4'd4,
        FN_INV_DST   = 4'd5,
        FN_SA        = 4'd6,
        FN_INV_SA    = 4'd7,
        FN_DA        = 4'd8,
        FN_INV_DA    = 4'd9,
        FN_CONST     = 4'd10,
        FN_INV_CONST = 4'd11,
        FN_CA        = 4'd12,
        FN_INV_CA    = 4'd13,
        FN_SATURATE  = 4'd14,
        FN_KEEP      = 4'd15
    } blend_fn_t;

    // Alpha-derived factors for the lanes; only sat differs on the alpha lane
    typedef struct packed {
        logic [CHAN_W-1:0] sa;
        logic [CHAN_W-1:0] da;
        logic [CHAN_W-1:0] ca;
        logic [CHAN_W-1:0] sat;
    } shared_fac_t;

    // Exact floor(p / 255) for any product of two 8-bit values
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = {1'b0, p} + {{(CHAN_W+1){1'b0}}, p[PROD_W-1:CHAN_W]} + 17'd1;
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

`default_nettype wire

FILE: sv/blend_factor_apply.sv
// ----------------------------------------------------------------------------
// blend_factor_apply
// RGBA8 blend factor scaling, one pixel per clock while not stalled.
// ----------------------------------------------------------------------------
// Scales each channel of value_rgba by the blend factor picked with func and
// gives floor(value * factor / 255) per channel, exact in integers. Factors
// come from src_rgba, dst_rgba or the constant colour in blend_color, which
// is loaded through cfg_we / cfg_wdata and must only be written while no
// transaction is in flight. Throughput is one transaction per clock while
// in_stall is low; an accepted pixel is registered after the 8x8
// multipliers and again in the output stage. A two-entry output buffer
// (output register plus skid) keeps in_stall a registered signal: it rises
// only after the output side has stalled with both entries occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module blend_factor_apply (
    input  wire                          clk,
    input  wire                          rst_n,
    // configuration
    input  wire                          cfg_we,
    input  wire  [bfa_pkg::PIX_W-1:0]    cfg_wdata,
    // input transactions
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire  [3:0]                   func,
    input  wire  [bfa_pkg::PIX_W-1:0]    value_rgba,
    input  wire  [bfa_pkg::PIX_W-1:0]    src_rgba,
    input  wire  [bfa_pkg::PIX_W-1:0]    dst_rgba,
    input  wire                          last_in,
    // output transactions
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [bfa_pkg::PIX_W-1:0]    result_rgba,
    output logic                         last_out
);
    import bfa_pkg::*;

    logic [PIX_W-1:0]   blend_color_reg;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_last_reg;
    logic               ready;
    logic               accept;
    blend_fn_t          fn;

    logic [CHAN_W-1:0]  sa, da, ca, inv_da, sat;
    shared_fac_t        fac_lane [LANES];
    logic [LANES-1:0][CHAN_W-1:0] lane_q;

    // whole front pipe moves together while the output buffer has room
    assign accept   = in_valid && ready;
    assign in_stall = !ready;
    assign fn       = blend_fn_t'(func);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_color_reg <= '0;
        end
        else if (cfg_we)
        begin
            blend_color_reg <= cfg_wdata;
        end
    end

    // alpha terms shared by all lanes
    assign sa     = src_rgba[PIX_W-1 -: CHAN_W];
    assign da     = dst_rgba[PIX_W-1 -: CHAN_W];
    assign ca     = blend_color_reg[PIX_W-1 -: CHAN_W];
    assign inv_da = CHAN_MAX - da;
    assign sat    = (sa < inv_da) ? sa : inv_da;

    // saturate leaves alpha alone: that lane gets a unit factor
    generate
        for (genvar k = 0; k < LANES; k++)
        begin : g_lane
            always_comb
            begin
                fac_lane[k].sa  = sa;
                fac_lane[k].da  = da;
                fac_lane[k].ca  = ca;
                fac_lane[k].sat = (k == LANES - 1) ? CHAN_MAX : sat;
            end

            bfa_lane u_lane (
                .clk        (clk),
                .en         (ready),
                .fn         (fn),
                .v          (value_rgba[k*CHAN_W +: CHAN_W]),
                .sc         (src_rgba[k*CHAN_W +: CHAN_W]),
                .dc         (dst_rgba[k*CHAN_W +: CHAN_W]),
                .kc         (blend_color_reg[k*CHAN_W +: CHAN_W]),
                .shared_fac (fac_lane[k]),
                .q          (lane_q[k])
            );
        end
    endgenerate

    // product stage valid and span marker
    assign s1_valid_next = ready ? accept : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            s1_last_reg <= last_in;
        end
    end

    bfa_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (s1_valid_reg && ready),
        .lane_q      (lane_q),
        .last_i      (s1_last_reg),
        .ready       (ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_rgba (result_rgba),
        .last_out    (last_out)
    );

endmodule

`default_nettype wire

FILE: sv/bfa_lane.sv
// ----------------------------------------------------------------------------
// bfa_lane
// One channel: factor select, 8x8 multiply into a register, divide by 255.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_lane (
    input  wire                          clk,
    input  wire                          en,
    input  bfa_pkg::blend_fn_t           fn,
    input  wire  [bfa_pkg::CHAN_W-1:0]   v,
    input  wire  [bfa_pkg::CHAN_W-1:0]   sc,
    input  wire  [bfa_pkg::CHAN_W-1:0]   dc,
    input  wire  [bfa_pkg::CHAN_W-1:0]   kc,
    input  bfa_pkg::shared_fac_t         shared_fac,
    output logic [bfa_pkg::CHAN_W-1:0]   q
);
    import bfa_pkg::*;

    logic [CHAN_W-1:0] factor;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    always_comb
    begin
        case (fn)
            FN_ZERO:            factor = '0;
            FN_SRC:             factor = sc;
            FN_INV_SRC:         factor = CHAN_MAX - sc;
            FN_DST:             factor = dc;
            FN_INV_DST:         factor = CHAN_MAX - dc;
            FN_SA:              factor = shared_fac.sa;
            FN_INV_SA:          factor = CHAN_MAX - shared_fac.sa;
            FN_DA:              factor = shared_fac.da;
            FN_INV_DA:          factor = CHAN_MAX - shared_fac.da;
            FN_CONST:           factor = kc;
            FN_INV_CONST:       factor = CHAN_MAX - kc;
            FN_CA:              factor = shared_fac.ca;
            FN_INV_CA:          factor = CHAN_MAX - shared_fac.ca;
            FN_SATURATE:        factor = shared_fac.sat;
            FN_ONE, FN_KEEP:    factor = CHAN_MAX;  // x*255/255 == x
            default:            factor = CHAN_MAX;
        endcase
    end

    assign prod_next = PROD_W'(v) * PROD_W'(factor);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign q = div255(prod_reg);

endmodule

`default_nettype wire

FILE: sv/bfa_merge.sv
// ----------------------------------------------------------------------------
// bfa_merge
// Packs the lane results into a pixel; output register plus skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_merge (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         take,
    input  wire  [bfa_pkg::LANES-1:0][bfa_pkg::CHAN_W-1:0] lane_q,
    input  wire                                         last_i,
    output logic                                        ready,
    output logic                                        out_valid,
    input  wire                                         out_stall,
    output logic [bfa_pkg::PIX_W-1:0]                   result_rgba,
    output logic                                        last_out
);
    import bfa_pkg::*;

    logic [PIX_W-1:0] pix;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [PIX_W-1:0] out_pix_reg, skid_pix_reg;
    logic             out_last_reg, skid_last_reg;
    logic             pop;
    logic             load_out, load_skid, move_skid;

    assign pix  = lane_q;
    assign pop  = out_valid_reg && !out_stall;

    // take only arrives while the skid stage is empty
    assign load_out  = take && (!out_valid_reg || !out_stall);
    assign load_skid = take && out_valid_reg && out_stall;
    assign move_skid = !take && pop && skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (load_out || move_skid)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load_skid)
        begin
            skid_valid_next = 1'b1;
        end
        else if (move_skid)
        begin
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_pix_reg  <= pix;
            out_last_reg <= last_i;
        end
        else if (move_skid)
        begin
            out_pix_reg  <= skid_pix_reg;
            out_last_reg <= skid_last_reg;
        end
        if (load_skid)
        begin
            skid_pix_reg  <= pix;
            skid_last_reg <= last_i;
        end
    end

    assign ready       = !skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign result_rgba = out_pix_reg;
    assign last_out    = out_last_reg;

endmodule

`default_nettype wire

FILE: sv/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks on the blend factor block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "blend_factor_apply_macros.svh"

module bfa_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_stall,
    input wire                          out_valid,
    input wire                          out_stall,
    input wire [bfa_pkg::PIX_W-1:0]     result_rgba,
    input wire                          last_out
);

    // stalled output transaction holds
    `BFA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "output valid dropped while stalled")
    `BFA_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(result_rgba) && $stable(last_out), "output payload moved while stalled")

    // input stall only follows an output stall
    `BFA_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, $past(out_valid && out_stall), "input stalled without output back-pressure")
    `BFA_ASSERT_IMP(a_stall_empty, clk, rst_n, !out_valid, !in_stall, "input stalled with output empty")

endmodule

bind blend_factor_apply bfa_checker u_bfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_rgba (result_rgba),
    .last_out    (last_out)
);

`default_nettype wire
